// ===== design/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular deque.
// Operation and status codes, fixed field widths, capacity reset value.
// No dependencies.
package cdq_pkg;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 8;
	localparam int RESULT_W = 32;
	localparam int CAP_RESET = 128;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INS_FRONT = 3'd0,
		FUNC_INS_REAR  = 3'd1,
		FUNC_DEL_FRONT = 3'd2,
		FUNC_DEL_REAR  = 3'd3,
		FUNC_RD_FRONT  = 3'd4,
		FUNC_RD_REAR   = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

endpackage

// ===== design/circular_deque_top.sv =====
// circular_deque_top: circular-array deque with a capacity register.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
// One operation is taken per clock whenever start is high (busy stays low)
// and capacity_we is low; its result appears with done in the next cycle,
// via the registered read of the store. Pointers move at the accepting
// edge, so a read right after an insert sees the new element without
// forwarding. Writing capacity empties the deque; a value of zero acts as
// one and values above DEPTH act as DEPTH. The result cannot be stalled.
module circular_deque_top #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [cdq_pkg::FUNC_W-1:0]  func,
	input  logic [DATA_WIDTH-1:0]       value,
	input  logic                        capacity_we,
	input  logic [cdq_pkg::CAP_W-1:0]   capacity_wdata,
	output logic                        done,
	output logic [cdq_pkg::RESULT_W-1:0] read_data,
	output logic [cdq_pkg::STATUS_W-1:0] status,
	output logic                        is_full,
	output logic                        is_empty
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	logic [CW-1:0]         cap_used_q;
	logic [CW-1:0]         cap_clamped;
	logic                  accept;
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [DATA_WIDTH-1:0] rd;
	status_t               status_w;
	logic [63:0]           rd_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		if (capacity_wdata == '0) begin
			cap_clamped = CW'(1);
		end else if (32'(capacity_wdata) > 32'(DEPTH)) begin
			cap_clamped = CW'(DEPTH);
		end else begin
			cap_clamped = CW'(capacity_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_used_q <= CW'(CAP_INIT);
		end else if (capacity_we) begin
			cap_used_q <= cap_clamped;
		end
	end

	cdq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.value     (value),
		.cap_used  (cap_used_q),
		.clear     (capacity_we),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.done      (done),
		.rd        (rd),
		.status    (status_w),
		.is_full   (is_full),
		.is_empty  (is_empty)
	);

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ext    = 64'(rd);
	assign read_data = rd_ext[RESULT_W-1:0];
	assign status    = status_w;

`ifndef SYNTHESIS
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_full && is_empty))
		else $error("deque reported full and empty at once");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !capacity_we) |=> done)
		else $error("accepted beat produced no result");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_w == ST_OVERFLOW) |-> is_full)
		else $error("overflow reported while not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_w == ST_UNDERFLOW) |-> is_empty)
		else $error("underflow reported while not empty");
`endif

endmodule

// ===== design/cdq_ram.sv =====
// cdq_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/cdq_ctrl.sv =====
// cdq_ctrl: head/tail pointers, empty flag, store access and result stage.
// Depends on cdq_pkg; drives one cdq_ram instance.
module cdq_ctrl #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [cdq_pkg::FUNC_W-1:0] func,
	input  logic [DATA_WIDTH-1:0]     value,
	input  logic [CW-1:0]             cap_used,
	input  logic                      clear,
	output logic                      ram_we,
	output logic [AW-1:0]             ram_waddr,
	output logic [DATA_WIDTH-1:0]     ram_wdata,
	output logic                      ram_re,
	output logic [AW-1:0]             ram_raddr,
	input  logic [DATA_WIDTH-1:0]     ram_rdata,
	output logic                      done,
	output logic [DATA_WIDTH-1:0]     rd,
	output cdq_pkg::status_t          status,
	output logic                      is_full,
	output logic                      is_empty
);
	import cdq_pkg::*;

	logic [AW-1:0] head_q, tail_q;
	logic          empty_q;
	logic [AW-1:0] head_d, tail_d;
	logic          empty_d;

	logic [CW-1:0] head_inc, tail_inc;
	logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
	logic          full_now;

	status_t st_d;
	logic    rd_mem_d, rd_neg_d;

	logic    done_s1;
	status_t status_s1;
	logic    rd_mem_s1, rd_neg_s1;

	// wrap within the capacity in use
	assign head_inc  = CW'(head_q) + CW'(1);
	assign tail_inc  = CW'(tail_q) + CW'(1);
	assign head_next = (head_inc >= cap_used) ? '0 : AW'(head_inc);
	assign tail_next = (tail_inc >= cap_used) ? '0 : AW'(tail_inc);
	assign head_prev = (head_q == '0) ? AW'(cap_used - CW'(1)) : head_q - AW'(1);
	assign tail_prev = (tail_q == '0) ? AW'(cap_used - CW'(1)) : tail_q - AW'(1);
	assign full_now  = !empty_q && (tail_next == head_q);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		empty_d   = empty_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = value;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		st_d      = ST_OK;
		rd_mem_d  = 1'b0;
		rd_neg_d  = 1'b0;
		if (clear) begin
			head_d  = '0;
			tail_d  = '0;
			empty_d = 1'b1;
		end else if (accept) begin
			case (func_t'(func))
				FUNC_INS_FRONT, FUNC_INS_REAR: begin
					if (full_now) begin
						st_d = ST_OVERFLOW;
					end else if (empty_q) begin
						head_d    = '0;
						tail_d    = '0;
						empty_d   = 1'b0;
						ram_we    = 1'b1;
						ram_waddr = '0;
					end else if (func_t'(func) == FUNC_INS_FRONT) begin
						head_d    = head_prev;
						ram_we    = 1'b1;
						ram_waddr = head_prev;
					end else begin
						tail_d    = tail_next;
						ram_we    = 1'b1;
						ram_waddr = tail_next;
					end
				end
				FUNC_DEL_FRONT, FUNC_DEL_REAR: begin
					if (empty_q) begin
						st_d = ST_UNDERFLOW;
					end else if (head_q == tail_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else if (func_t'(func) == FUNC_DEL_FRONT) begin
						head_d = head_next;
					end else begin
						tail_d = tail_prev;
					end
				end
				FUNC_RD_FRONT, FUNC_RD_REAR: begin
					if (empty_q) begin
						st_d     = ST_UNDERFLOW;
						rd_neg_d = 1'b1;
					end else begin
						ram_re    = 1'b1;
						rd_mem_d  = 1'b1;
						ram_raddr = (func_t'(func) == FUNC_RD_FRONT) ? head_q : tail_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			done_s1 <= accept && !clear;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= st_d;
		rd_mem_s1 <= rd_mem_d;
		rd_neg_s1 <= rd_neg_d;
	end

	// flags come from the pointer state, which already holds this beat's update
	assign done     = done_s1;
	assign status   = status_s1;
	assign rd       = rd_mem_s1 ? ram_rdata : {DATA_WIDTH{rd_neg_s1}};
	assign is_full  = full_now;
	assign is_empty = empty_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for circular_deque_top, one beat per operation.
// Built-in deque predictor, directed and random tests over many capacity settings.
// Depends on cdq_pkg and the circular_deque_top RTL.
module tb_top;
	import cdq_pkg::*;

	localparam int DQ_DEPTH = 128;
	localparam int DQ_WIDTH = 32;
	localparam int IDX_W = $clog2(DQ_DEPTH);
	localparam int PHASE_BEATS = 160;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 100;
	localparam logic [FUNC_W-1:0] FUNC_UNDEF_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_UNDEF_7 = 3'd7;

	typedef struct {
		int unsigned          seq;
		logic [DQ_WIDTH-1:0]  read_data;
		status_t              status;
		logic                 is_full;
		logic                 is_empty;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [FUNC_W-1:0] func = '0;
	logic [DQ_WIDTH-1:0] value = '0;
	logic capacity_we = 1'b0;
	logic [CAP_W-1:0] capacity_wdata = '0;
	logic done;
	logic [RESULT_W-1:0] read_data;
	logic [STATUS_W-1:0] status;
	logic is_full;
	logic is_empty;

	// predictor state
	logic [DQ_WIDTH-1:0] dq_store [DQ_DEPTH];
	logic [IDX_W-1:0] dq_head = '0;
	logic [IDX_W-1:0] dq_tail = '0;
	logic dq_empty = 1'b1;
	logic [CAP_W-1:0] cap_reg = CAP_W'(CAP_RESET);

	deque_result_t pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned beat_count = 0;
	int unsigned calm_beats = 0;
	int unsigned cycle_count = 0;

	circular_deque_top #(
		.DEPTH(DQ_DEPTH),
		.DATA_WIDTH(DQ_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.done(done),
		.read_data(read_data),
		.status(status),
		.is_full(is_full),
		.is_empty(is_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned cap_in_use();
		if (cap_reg == 0) return 1;
		if (cap_reg > DQ_DEPTH) return DQ_DEPTH;
		return cap_reg;
	endfunction

	function automatic logic [IDX_W-1:0] pos_next(logic [IDX_W-1:0] i, int unsigned cap);
		return (int'(i) + 1 >= cap) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] pos_prev(logic [IDX_W-1:0] i, int unsigned cap);
		return (i == 0) ? IDX_W'(cap - 1) : i - 1'b1;
	endfunction

	function automatic logic deque_full();
		return !dq_empty && pos_next(dq_tail, cap_in_use()) == dq_head;
	endfunction

	function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] op,
			logic [DQ_WIDTH-1:0] val, int unsigned seq);
		deque_result_t r;
		int unsigned cap;
		cap = cap_in_use();
		r.seq = seq;
		r.read_data = '0;
		r.status = ST_OK;
		case (op)
			FUNC_INS_FRONT, FUNC_INS_REAR: begin
				if (deque_full()) begin
					r.status = ST_OVERFLOW;
				end else if (dq_empty) begin
					dq_head = '0;
					dq_tail = '0;
					dq_empty = 1'b0;
					dq_store[0] = val;
				end else if (op == FUNC_INS_FRONT) begin
					dq_head = pos_prev(dq_head, cap);
					dq_store[dq_head] = val;
				end else begin
					dq_tail = pos_next(dq_tail, cap);
					dq_store[dq_tail] = val;
				end
			end
			FUNC_DEL_FRONT, FUNC_DEL_REAR: begin
				if (dq_empty) begin
					r.status = ST_UNDERFLOW;
				end else if (dq_head == dq_tail) begin
					dq_head = '0;
					dq_tail = '0;
					dq_empty = 1'b1;
				end else if (op == FUNC_DEL_FRONT) begin
					dq_head = pos_next(dq_head, cap);
				end else begin
					dq_tail = pos_prev(dq_tail, cap);
				end
			end
			FUNC_RD_FRONT, FUNC_RD_REAR: begin
				if (dq_empty) begin
					r.status = ST_UNDERFLOW;
					r.read_data = '1;
				end else begin
					r.read_data = dq_store[(op == FUNC_RD_FRONT) ? dq_head : dq_tail];
				end
			end
			default: ;
		endcase
		r.is_full = deque_full();
		r.is_empty = dq_empty;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned seq,
			input logic [DQ_WIDTH-1:0] got, input logic [DQ_WIDTH-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH beat %0d %s: got %h expected %h", seq, what, got, want);
	endtask

	// one beat; start stays high across back-to-back beats
	task automatic send_op(input logic [FUNC_W-1:0] op, input logic [DQ_WIDTH-1:0] val);
		int unsigned gap;
		if (calm_beats > 0) begin
			gap = 0;
			calm_beats--;
		end else begin
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 11) == 0) calm_beats = $urandom_range(4, 32);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		value <= val;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(deque_apply(op, val, beat_count));
		beat_count++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_capacity(input logic [CAP_W-1:0] cap);
		drain_results();
		repeat (2) @(posedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= cap;
		@(posedge clk);
		capacity_we <= 1'b0;
		cap_reg = cap;
		dq_head = '0;
		dq_tail = '0;
		dq_empty = 1'b1;
	endtask

	task automatic test_empty_after_reset();
		send_op(FUNC_RD_FRONT, $urandom);
		send_op(FUNC_RD_REAR, $urandom);
		send_op(FUNC_DEL_FRONT, $urandom);
		send_op(FUNC_DEL_REAR, $urandom);
		send_op(FUNC_UNDEF_6, $urandom);
		send_op(FUNC_UNDEF_7, $urandom);
	endtask

	task automatic test_value_extremes();
		send_op(FUNC_INS_REAR, 32'h7fff_ffff);
		send_op(FUNC_INS_FRONT, 32'h8000_0000);
		send_op(FUNC_RD_FRONT, '0);
		send_op(FUNC_RD_REAR, '0);
		send_op(FUNC_INS_REAR, 32'h0000_0000);
		send_op(FUNC_INS_FRONT, 32'hffff_ffff);
		send_op(FUNC_RD_FRONT, '0);
		send_op(FUNC_UNDEF_7, $urandom);
		send_op(FUNC_DEL_FRONT, '0);
		send_op(FUNC_DEL_REAR, '0);
		send_op(FUNC_RD_REAR, '0);
		send_op(FUNC_DEL_REAR, '0);
		send_op(FUNC_DEL_FRONT, '0);
		send_op(FUNC_RD_REAR, '0);
	endtask

	// zero acts as a capacity of one
	task automatic test_min_capacity();
		cfg_capacity(8'd0);
		send_op(FUNC_INS_FRONT, 32'h1234_5678);
		send_op(FUNC_INS_REAR, 32'hdead_beef);
		send_op(FUNC_RD_REAR, '0);
		send_op(FUNC_DEL_REAR, '0);
	endtask

	task automatic test_random_phases();
		logic [CAP_W-1:0] caps [12] = '{8'd255, 8'd1, 8'd2, 8'd3, 8'd5, 8'd17,
			8'd64, 8'd129, 8'd128, 8'd0, 8'd7, 8'd100};
		int unsigned n, seg_left, mode, roll, ins_pct, del_pct;
		logic [FUNC_W-1:0] op;
		logic [DQ_WIDTH-1:0] val;
		foreach (caps[p]) begin
			cfg_capacity(caps[p]);
			n = 0;
			seg_left = 0;
			mode = 0;
			// fill past full to hit overflow and the wrap points
			repeat (cap_in_use() + 2) begin
				send_op($urandom_range(0, 1) ? FUNC_INS_FRONT : FUNC_INS_REAR, $urandom);
				n++;
			end
			while (n < PHASE_BEATS) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 40);
					mode = $urandom_range(0, 2);
					if ($urandom_range(0, 5) == 0) drain_results();
				end
				ins_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
				del_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
				roll = $urandom_range(0, 99);
				if (roll < 2)
					op = $urandom_range(0, 1) ? FUNC_UNDEF_6 : FUNC_UNDEF_7;
				else if (roll < ins_pct)
					op = $urandom_range(0, 1) ? FUNC_INS_FRONT : FUNC_INS_REAR;
				else if (roll < ins_pct + del_pct)
					op = $urandom_range(0, 1) ? FUNC_DEL_FRONT : FUNC_DEL_REAR;
				else
					op = $urandom_range(0, 1) ? FUNC_RD_FRONT : FUNC_RD_REAR;
				case ($urandom_range(0, 19))
					0: val = 32'h8000_0000;
					1: val = 32'h7fff_ffff;
					2: val = '1;
					3: val = '0;
					default: val = $urandom;
				endcase
				send_op(op, val);
				n++;
				seg_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done unknown", beat_count, done, 1'b0);
			end else if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("beat with nothing expected", beat_count, read_data, '0);
				end else begin
					exp_r = pending_results.pop_front();
					if (read_data !== exp_r.read_data)
						report_mismatch("read_data", exp_r.seq, read_data, exp_r.read_data);
					if (status !== exp_r.status)
						report_mismatch("status", exp_r.seq, status, exp_r.status);
					if (is_full !== exp_r.is_full)
						report_mismatch("is_full", exp_r.seq, is_full, exp_r.is_full);
					if (is_empty !== exp_r.is_empty)
						report_mismatch("is_empty", exp_r.seq, is_empty, exp_r.is_empty);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_after_reset();
		test_value_extremes();
		test_min_capacity();
		test_random_phases();
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/circular_deque_top.sv
dv/tb_top.sv
